/* src/matrix_inverse_3x3_core_defines.svh */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core_defines
// assertion macros shared by the matrix inverse core
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MI_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define MI_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* src/minv3_pkg.sv */
// ----------------------------------------------------------------------------
// minv3_pkg
// types and widths for the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
package minv3_pkg;

   localparam int N_ELEM = 9;
   localparam int REM_W  = 57;
   localparam int DM_W   = 50;
   localparam int QUO_W  = 32;
   localparam int DET_W  = 51;
   localparam int CMP_W  = 83;
   localparam int N_DIV  = 33;

   typedef logic signed [15:0]    elem_type;
   typedef logic signed [31:0]    prod_type;
   typedef logic signed [32:0]    cof_type;
   typedef logic signed [48:0]    dprod_type;
   typedef logic signed [DET_W-1:0] det_type;

   typedef struct packed {
      logic                            valid;
      logic                            sing;
      det_type                         det;
      logic [DM_W-1:0]                 dm;
      logic [N_ELEM-1:0]               neg;
      logic [N_ELEM-1:0]               ovf;
      logic [N_ELEM-1:0][REM_W-1:0]    rem;
      logic [N_ELEM-1:0][QUO_W-1:0]    quo;
   } div_stage_type;

endpackage

/* src/matrix_inverse_3x3_core.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// pipelined 3x3 fixed point matrix inverse by the adjugate
// ----------------------------------------------------------------------------
// usage:
//  - a request carries nine signed Q8.8 elements on req_a00..req_a22 and is
//    taken when req_valid and req_ready are both high
//  - the response carries the Q16.16 inverse on rsp_inv00..rsp_inv22, the
//    exact Q24.24 determinant and the singular flag, under rsp_valid/rsp_ready
//  - one request per cycle is taken while the response side keeps up
//  - four stages of products, cofactors and determinant feed a restoring
//    divider of 33 stages; its top stage detects overflow and each stage
//    below it gives one quotient bit
//  - a singular matrix returns zero inverse elements with singular set
//  - when the receiver stalls with a response pending, the whole pipeline
//    holds and req_ready drops; nothing is lost or repeated
//  - reset clears all valid bits; the pipeline comes up empty
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_core_defines.svh"

module matrix_inverse_3x3_core
   import minv3_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [15:0]   req_a00,
   input  logic [15:0]   req_a01,
   input  logic [15:0]   req_a02,
   input  logic [15:0]   req_a10,
   input  logic [15:0]   req_a11,
   input  logic [15:0]   req_a12,
   input  logic [15:0]   req_a20,
   input  logic [15:0]   req_a21,
   input  logic [15:0]   req_a22,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_inv00,
   output logic [31:0]   rsp_inv01,
   output logic [31:0]   rsp_inv02,
   output logic [31:0]   rsp_inv10,
   output logic [31:0]   rsp_inv11,
   output logic [31:0]   rsp_inv12,
   output logic [31:0]   rsp_inv20,
   output logic [31:0]   rsp_inv21,
   output logic [31:0]   rsp_inv22,
   output logic [50:0]   rsp_determinant,
   output logic          rsp_singular
);

   logic                       en;
   elem_type                   a_in [N_ELEM];

   logic                       s1_valid_ff;
   elem_type                   a1_ff [3];
   prod_type                   p1_ff [N_ELEM];
   prod_type                   p2_ff [N_ELEM];

   logic                       s2_valid_ff;
   elem_type                   a2_ff [3];
   cof_type                    cof2_ff [N_ELEM];

   logic                       s3_valid_ff;
   dprod_type                  dp3_ff [3];
   cof_type                    cof3_ff [N_ELEM];

   logic                       s4_valid_ff;
   det_type                    det4_ff;
   cof_type                    cof4_ff [N_ELEM];

   div_stage_type              dv_in [N_DIV+1];
   div_stage_type              dv_ff [N_DIV+1];

   logic                       rsp_valid_ff;
   logic [QUO_W-1:0]           inv_ff [N_ELEM];
   logic [QUO_W-1:0]           inv_in [N_ELEM];
   det_type                    det_ff;
   logic                       sing_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign a_in[0] = req_a00;
   assign a_in[1] = req_a01;
   assign a_in[2] = req_a02;
   assign a_in[3] = req_a10;
   assign a_in[4] = req_a11;
   assign a_in[5] = req_a12;
   assign a_in[6] = req_a20;
   assign a_in[7] = req_a21;
   assign a_in[8] = req_a22;

   // stage 1: cofactor products
   genvar gi, gj;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_row
         for (gj = 0; gj < 3; gj++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            always_ff @(posedge clock) begin
               if (en) begin
                  p1_ff[gi*3+gj] <= prod_type'(a_in[I1*3+J1]) * prod_type'(a_in[I2*3+J2]);
                  p2_ff[gi*3+gj] <= prod_type'(a_in[I1*3+J2]) * prod_type'(a_in[I2*3+J1]);
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a1_ff[k]  <= a_in[k];
            a2_ff[k]  <= a1_ff[k];
            // stage 3: first row times cofactors
            dp3_ff[k] <= dprod_type'(a2_ff[k]) * dprod_type'(cof2_ff[k]);
         end
         for (int k = 0; k < N_ELEM; k++) begin
            cof2_ff[k] <= cof_type'(p1_ff[k]) - cof_type'(p2_ff[k]);
            cof3_ff[k] <= cof2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
         end
         det4_ff <= det_type'(dp3_ff[0]) + det_type'(dp3_ff[1]) + det_type'(dp3_ff[2]);
      end
   end

   // divider setup: magnitudes and signs
   always_comb begin
      logic [32:0] cmag;
      logic [DET_W-1:0] dmag;
      dv_in[0]       = '0;
      dmag           = det4_ff[DET_W-1] ? DET_W'(-det4_ff) : DET_W'(det4_ff);
      dv_in[0].valid = s4_valid_ff;
      dv_in[0].det   = det4_ff;
      dv_in[0].sing  = (det4_ff == '0);
      dv_in[0].dm    = dmag[DM_W-1:0];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cmag = cof4_ff[j*3+i][32] ? 33'(-cof4_ff[j*3+i]) : 33'(cof4_ff[j*3+i]);
            dv_in[0].neg[i*3+j] = cof4_ff[j*3+i][32] ^ det4_ff[DET_W-1];
            dv_in[0].rem[i*3+j] = {1'b0, cmag[31:0], 24'b0};
         end
      end
   end

   // restoring divider, one quotient bit per stage, top stage detects overflow
   genvar gs;
   generate
      for (gs = 0; gs < N_DIV; gs++) begin : g_div
         localparam int K = N_DIV - 1 - gs;
         if (K == QUO_W) begin : g_ovf
            always_comb begin
               logic [CMP_W-1:0] dsh;
               dv_in[gs+1] = dv_ff[gs];
               dsh = CMP_W'(dv_ff[gs].dm) << K;
               for (int e = 0; e < N_ELEM; e++) begin
                  dv_in[gs+1].ovf[e] = CMP_W'(dv_ff[gs].rem[e]) >= dsh;
               end
            end
         end else begin : g_bit
            always_comb begin
               logic [CMP_W-1:0] dsh;
               dv_in[gs+1] = dv_ff[gs];
               dsh = CMP_W'(dv_ff[gs].dm) << K;
               for (int e = 0; e < N_ELEM; e++) begin
                  if (CMP_W'(dv_ff[gs].rem[e]) >= dsh) begin
                     dv_in[gs+1].rem[e]    = dv_ff[gs].rem[e] - dsh[REM_W-1:0];
                     dv_in[gs+1].quo[e][K] = 1'b1;
                  end
               end
            end
         end
      end
   endgenerate

   generate
      for (gs = 0; gs <= N_DIV; gs++) begin : g_dreg
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[gs].valid <= 1'b0;
            end else if (en) begin
               dv_ff[gs] <= dv_in[gs];
            end
         end
      end
   endgenerate

   // sign, saturation and singular zeroing
   always_comb begin
      logic [QUO_W-1:0] q;
      for (int e = 0; e < N_ELEM; e++) begin
         q = dv_ff[N_DIV].quo[e];
         if (dv_ff[N_DIV].sing) begin
            inv_in[e] = '0;
         end else if (dv_ff[N_DIV].neg[e]) begin
            if (dv_ff[N_DIV].ovf[e] || q > 32'h8000_0000) begin
               inv_in[e] = 32'h8000_0000;
            end else begin
               inv_in[e] = -q;
            end
         end else begin
            if (dv_ff[N_DIV].ovf[e] || q[QUO_W-1]) begin
               inv_in[e] = 32'h7fff_ffff;
            end else begin
               inv_in[e] = q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[N_DIV].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff  <= inv_in;
         det_ff  <= dv_ff[N_DIV].det;
         sing_ff <= dv_ff[N_DIV].sing;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inv00       = inv_ff[0];
   assign rsp_inv01       = inv_ff[1];
   assign rsp_inv02       = inv_ff[2];
   assign rsp_inv10       = inv_ff[3];
   assign rsp_inv11       = inv_ff[4];
   assign rsp_inv12       = inv_ff[5];
   assign rsp_inv20       = inv_ff[6];
   assign rsp_inv21       = inv_ff[7];
   assign rsp_inv22       = inv_ff[8];
   assign rsp_determinant = det_ff;
   assign rsp_singular    = sing_ff;

   `MI_ASSERT_IMPL(a_sing_zero, rsp_valid && rsp_singular, rsp_determinant == '0 && rsp_inv00 == '0 && rsp_inv11 == '0 && rsp_inv22 == '0, "singular response with nonzero fields")
   `MI_ASSERT_IMPL(a_det_nonzero, rsp_valid && !rsp_singular, rsp_determinant != '0, "zero determinant without singular flag")
   `MI_ASSERT_NEXT(a_tail_to_out, dv_ff[N_DIV].valid && en, rsp_valid, "pipeline tail lost an item")

endmodule
